FILE: rtl/core/sclru_pkg.sv
// Shared types and constants of the sector cache LRU tag directory.
// Used by every module under rtl/core but sclru_ram; depends on nothing.
`default_nettype none

package sclru_pkg;

  localparam int DRIVE_W = 8;
  localparam int STAMP_W = 32;
  localparam int CODE_W  = 3;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 8;
  localparam int REQ_SECTOR_W = 32;

  // request kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // the two drives that may be cached
  localparam logic [DRIVE_W-1:0] DRV_FIRST  = 8'd0;
  localparam logic [DRIVE_W-1:0] DRV_SECOND = 8'd1;

  // result codes
  localparam logic [CODE_W-1:0] RC_HIT    = 3'd0;
  localparam logic [CODE_W-1:0] RC_READ   = 3'd1;
  localparam logic [CODE_W-1:0] RC_XFER   = 3'd2;
  localparam logic [CODE_W-1:0] RC_DEVERR = 3'd3;
  localparam logic [CODE_W-1:0] RC_BADDRV = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_ONE = 8'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scan;
    logic scan_done;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/sector_cache_lru_directory.sv
// Top level of the sector cache LRU tag directory: controller plus datapath.
// Uses sclru_pkg, sclru_ctrl, sclru_datapath (which holds sclru_ram).
//
//   channel  ports                                          beat
//   in       in_valid/in_ready, op drive sector count ok    one request
//   out      out_valid/out_ready, result_code slot filled   one result
//
// A request that scans passes through accept in ST_IDLE, tag RAM reads in
// ST_SCAN (one read per entry behind the registered RAM port) and commit in
// ST_COMMIT. A read on a bad drive skips the scan and goes to commit.
// Reset clears the valid bits and the stamp counter at once; no clearing pass.
// A result waiting on out_ready holds the commit, and in_ready stays low
// until the commit is done.
`default_nettype none

module sector_cache_lru_directory #(
  parameter int ENTRIES     = 8,
  parameter int SECTOR_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_op,
  input  wire logic [sclru_pkg::DRIVE_W-1:0]      in_drive,
  input  wire logic [sclru_pkg::REQ_SECTOR_W-1:0] in_sector,
  input  wire logic [sclru_pkg::COUNT_W-1:0]      in_count,
  input  wire logic                               in_device_ok,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [sclru_pkg::CODE_W-1:0]       out_result_code,
  output logic      [sclru_pkg::SLOT_W-1:0]       out_slot,
  output logic                                    out_filled
);

  sclru_pkg::cmd_t cmd;
  sclru_pkg::sts_t sts;

  sclru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sclru_datapath #(
    .ENTRIES     (ENTRIES),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_drive        (in_drive),
    .in_sector       (in_sector),
    .in_count        (in_count),
    .in_device_ok    (in_device_ok),
    .out_result_code (out_result_code),
    .out_slot        (out_slot),
    .out_filled      (out_filled)
  );

  // after an accept, in_ready is low in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  // a commit always presents a result
  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit without out_valid");

  // only a device read can fill
  a_fill_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_filled) |-> (out_result_code == sclru_pkg::RC_READ))
    else $error("filled set on a result other than a device read");

  // transfers, errors and bad drives report slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_code != sclru_pkg::RC_HIT) &&
     (out_result_code != sclru_pkg::RC_READ)) |-> (out_slot == '0) && !out_filled)
    else $error("nonzero slot on a result without a cache slot");

endmodule

`default_nettype wire

FILE: rtl/core/sclru_ram.sv
// Generic single write port, single read port RAM with registered read.
// Holds the per-slot tag words; depends on nothing.
`default_nettype none

module sclru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sclru_datapath.sv
// Datapath of the sector cache directory: request registers, tag RAM, valid
// bits, scan trackers, stamp counter and result registers. Uses sclru_pkg, sclru_ram.
`default_nettype none

module sclru_datapath #(
  parameter int ENTRIES     = 8,
  parameter int SECTOR_BITS = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire sclru_pkg::cmd_t                       cmd,
  output sclru_pkg::sts_t                            sts,
  input  wire logic                                  in_op,
  input  wire logic [sclru_pkg::DRIVE_W-1:0]         in_drive,
  input  wire logic [sclru_pkg::REQ_SECTOR_W-1:0]    in_sector,
  input  wire logic [sclru_pkg::COUNT_W-1:0]         in_count,
  input  wire logic                                  in_device_ok,
  output logic      [sclru_pkg::CODE_W-1:0]          out_result_code,
  output logic      [sclru_pkg::SLOT_W-1:0]          out_slot,
  output logic                                       out_filled
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WORD_W = sclru_pkg::DRIVE_W + SECTOR_BITS + sclru_pkg::STAMP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // request registers
  logic [sclru_pkg::DRIVE_W-1:0] req_drive_r;
  logic [SECTOR_BITS-1:0]        req_sec_r, req_top_r;
  logic                          req_ok_r, req_good_r, lookup_r, drop_r;

  // scan pipeline and trackers
  logic             rd_busy_r, cmp_vld_r;
  logic [IDX_W-1:0] rd_idx_r, cmp_idx_r;
  logic             hit_r, vic_inv_r, vic_found_r;
  logic [IDX_W-1:0] hit_idx_r, vic_idx_r;
  logic [sclru_pkg::STAMP_W-1:0] best_r, count_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  // tag RAM access
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;
  logic [sclru_pkg::STAMP_W-1:0] rd_stamp, stamp_nxt;
  logic [SECTOR_BITS-1:0]        rd_sector, in_sec;
  logic [sclru_pkg::DRIVE_W-1:0] rd_drive;
  logic                          in_good, in_lookup, in_drop;
  logic                          ent_valid, tag_match, in_range, do_fill;

  sclru_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_idx_r),
    .rdata (ram_rdata)
  );

  // request decode
  always_comb begin
    in_good   = in_drive inside {sclru_pkg::DRV_FIRST, sclru_pkg::DRV_SECOND};
    in_sec    = SECTOR_BITS'(in_sector);
    in_lookup = (in_op == sclru_pkg::OP_READ) && in_good &&
                (in_count == sclru_pkg::COUNT_ONE);
    in_drop   = (in_op == sclru_pkg::OP_WRITE) ||
                (in_good && (in_count != sclru_pkg::COUNT_ONE));
    sts.need_scan = in_lookup || in_drop;
    sts.scan_done = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  end

  // tag word fields and entry compare
  always_comb begin
    rd_stamp  = ram_rdata[sclru_pkg::STAMP_W-1:0];
    rd_sector = ram_rdata[sclru_pkg::STAMP_W +: SECTOR_BITS];
    rd_drive  = ram_rdata[sclru_pkg::STAMP_W + SECTOR_BITS +: sclru_pkg::DRIVE_W];
    ent_valid = valid_r[cmp_idx_r];
    tag_match = ent_valid && (rd_drive == req_drive_r);
    in_range  = (rd_sector >= req_sec_r) && (rd_sector < req_top_r);
    stamp_nxt = count_r + 32'd1;
  end

  // commit: refresh on hit, fill on good miss
  always_comb begin
    do_fill   = lookup_r && !hit_r && req_ok_r && vic_found_r;
    ram_we    = cmd.commit && lookup_r && (hit_r || do_fill);
    ram_waddr = hit_r ? hit_idx_r : vic_idx_r;
    ram_wdata = {req_drive_r, req_sec_r, stamp_nxt};
    ram_re    = cmd.scan && rd_busy_r;
  end

  // valid bits: drop during scan, set on fill
  always_comb begin
    valid_nxt = valid_r;
    if (cmp_vld_r && drop_r && tag_match && in_range) begin
      valid_nxt[cmp_idx_r] = 1'b0;
    end
    if (cmd.commit && do_fill) begin
      valid_nxt[vic_idx_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      count_r   <= '0;
      rd_busy_r <= 1'b0;
      cmp_vld_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      cmp_vld_r <= ram_re;
      if (ram_we) begin
        count_r <= stamp_nxt;
      end
      if (cmd.load) begin
        rd_busy_r <= sts.need_scan;
      end else if (ram_re && (rd_idx_r == LAST_IDX)) begin
        rd_busy_r <= 1'b0;
      end
    end
  end

  // request capture, read index and scan trackers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_drive_r <= in_drive;
      req_sec_r   <= in_sec;
      req_top_r   <= SECTOR_BITS'({1'b0, in_sec} + (SECTOR_BITS + 1)'(in_count));
      req_ok_r    <= in_device_ok;
      req_good_r  <= in_good;
      lookup_r    <= in_lookup;
      drop_r      <= in_drop;
      rd_idx_r    <= '0;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
      vic_inv_r   <= 1'b0;
      vic_found_r <= 1'b0;
      vic_idx_r   <= '0;
      best_r      <= '1;
    end else begin
      if (ram_re) begin
        cmp_idx_r <= rd_idx_r;
        if (rd_idx_r != LAST_IDX) begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end
      if (cmp_vld_r) begin
        // first hit wins
        if (!hit_r && tag_match && (rd_sector == req_sec_r)) begin
          hit_r     <= 1'b1;
          hit_idx_r <= cmp_idx_r;
        end
        // first invalid slot, else strictly smallest stamp
        if (!vic_inv_r) begin
          if (!ent_valid) begin
            vic_inv_r   <= 1'b1;
            vic_found_r <= 1'b1;
            vic_idx_r   <= cmp_idx_r;
          end else if (rd_stamp < best_r) begin
            vic_found_r <= 1'b1;
            vic_idx_r   <= cmp_idx_r;
            best_r      <= rd_stamp;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_slot   <= '0;
      out_filled <= 1'b0;
      if (!req_good_r) begin
        out_result_code <= sclru_pkg::RC_BADDRV;
      end else if (lookup_r) begin
        if (hit_r) begin
          out_result_code <= sclru_pkg::RC_HIT;
          out_slot        <= sclru_pkg::SLOT_W'(hit_idx_r);
        end else if (!req_ok_r) begin
          out_result_code <= sclru_pkg::RC_DEVERR;
        end else begin
          out_result_code <= sclru_pkg::RC_READ;
          if (vic_found_r) begin
            out_slot   <= sclru_pkg::SLOT_W'(vic_idx_r);
            out_filled <= 1'b1;
          end
        end
      end else begin
        out_result_code <= req_ok_r ? sclru_pkg::RC_XFER : sclru_pkg::RC_DEVERR;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/sclru_ctrl.sv
// Controller of the sector cache directory: idle, scan and commit sequencing
// and the output valid flag. Uses sclru_pkg.
`default_nettype none

module sclru_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire sclru_pkg::sts_t sts,
  output sclru_pkg::cmd_t      cmd
);

  sclru_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  // state and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sclru_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    in_ready   = 1'b0;
    case (state_r)
      sclru_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.need_scan ? sclru_pkg::ST_SCAN : sclru_pkg::ST_COMMIT;
        end
      end
      sclru_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = sclru_pkg::ST_COMMIT;
        end
      end
      sclru_pkg::ST_COMMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.commit = 1'b1;
          state_nxt  = sclru_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sclru_pkg::ST_IDLE;
      end
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
